// ----- hdl/sct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned COUNT_OUT_W = 7;

  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_GET    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SCALE  = 3'd4;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

`default_nettype wire

// ----- hdl/sparse_coordinate_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An unknown action answers in the cycle after start; a scale sweeps every entry, a lookup
// searches until it hits or reaches the last entry, and a remove that hits shifts entries down.
// One request at a time; start is ignored while busy, and each request is paced by
// the single read port of the entry memory, which is walked one entry per cycle.
// The result beat is shown for one cycle on out_strobe; the receiver cannot stall.
// Reset clears only the entry count and the control state; the memory needs no clearing.

module sparse_coordinate_table #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [sct_pkg::ACTION_W-1:0]      in_action,
  input  wire  [15:0]                       in_row_index,
  input  wire  [15:0]                       in_col_index,
  input  wire  signed [sct_pkg::VALUE_W-1:0] in_operand,
  output logic                              out_strobe,
  output logic signed [sct_pkg::VALUE_W-1:0] out_read_value,
  output logic                              out_hit,
  output logic                              out_status,
  output logic [sct_pkg::COUNT_OUT_W-1:0]   out_entry_count
);

  localparam int unsigned KEY_W = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int unsigned VW    = sct_pkg::VALUE_W;
  localparam int unsigned EW    = 2 * KEY_W + VW;
  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned OW    = sct_pkg::COUNT_OUT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [2:0]                       state_r, state_nxt;
  logic [sct_pkg::ACTION_W-1:0]     act_r, act_nxt;
  logic [KEY_W-1:0]                 row_r, row_nxt;
  logic [KEY_W-1:0]                 col_r, col_nxt;
  sct_pkg::value_t                  op_r, op_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    iss_r, iss_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [AW-1:0]                    pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]                    slot_r, slot_nxt;
  sct_pkg::value_t                  old_r, old_nxt;
  logic                             hit_r, hit_nxt;

  logic                             strobe_r, strobe_nxt;
  sct_pkg::value_t                  rval_r, rval_nxt;
  logic                             ohit_r, ohit_nxt;
  logic                             stat_r, stat_nxt;
  logic [OW-1:0]                    ocnt_r;

  logic [KEY_W-1:0]                 rd_row, rd_col;
  sct_pkg::value_t                  rd_val;
  sct_pkg::value_t                  product;
  logic                             match, last;
  logic [CW-1:0]                    cnt_last;
  logic [CW+OW-1:0]                 cnt_wide;

  assign rd_row   = rd_q[EW-1 -: KEY_W];
  assign rd_col   = rd_q[VW +: KEY_W];
  assign rd_val   = rd_q[VW-1:0];
  assign product  = rd_val * op_r;
  assign match    = (rd_row == row_r) && (rd_col == col_r);
  assign cnt_last = cnt_r - CW'(1);
  assign last     = (CW'(pend_idx_r) == cnt_last);
  assign cnt_wide = (CW + OW)'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    pend_v_nxt   = 1'b0;
    pend_idx_nxt = pend_idx_r;
    slot_nxt     = slot_r;
    old_nxt      = old_r;
    hit_nxt      = hit_r;
    strobe_nxt   = 1'b0;
    rval_nxt     = '0;
    ohit_nxt     = 1'b0;
    stat_nxt     = 1'b0;
    rd_addr      = iss_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = pend_idx_r;
    wr_data      = rd_q;

    if ((state_r == S_SEARCH || state_r == S_SWEEP) && (iss_r < cnt_r)) begin
      iss_nxt      = iss_r + CW'(1);
      pend_v_nxt   = 1'b1;
      pend_idx_nxt = iss_r[AW-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = in_action;
          row_nxt = in_row_index[KEY_W-1:0];
          col_nxt = in_col_index[KEY_W-1:0];
          op_nxt  = in_operand;
          hit_nxt = 1'b0;
          iss_nxt = '0;
          if (in_action inside {sct_pkg::ACT_SET, sct_pkg::ACT_ADD,
                                sct_pkg::ACT_GET, sct_pkg::ACT_REMOVE}) begin
            state_nxt = (cnt_r == '0) ? S_APPLY : S_SEARCH;
          end else if (in_action == sct_pkg::ACT_SCALE && cnt_r != '0) begin
            state_nxt = S_SWEEP;
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (pend_v_r) begin
          if (match) begin
            slot_nxt   = pend_idx_r;
            old_nxt    = rd_val;
            hit_nxt    = 1'b1;
            pend_v_nxt = 1'b0;
            state_nxt  = S_APPLY;
          end else if (last) begin
            hit_nxt    = 1'b0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        ohit_nxt   = hit_r;
        case (act_r)
          sct_pkg::ACT_SET, sct_pkg::ACT_ADD: begin
            if (hit_r) begin
              wr_en   = 1'b1;
              wr_addr = slot_r;
              wr_data = {row_r, col_r,
                         (act_r == sct_pkg::ACT_SET) ? op_r : old_r + op_r};
            end else if (cnt_r < CW'(CAPACITY)) begin
              wr_en   = 1'b1;
              wr_addr = cnt_r[AW-1:0];
              wr_data = {row_r, col_r, op_r};
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              stat_nxt = 1'b1;
            end
          end
          sct_pkg::ACT_GET: begin
            rval_nxt = hit_r ? old_r : '0;
          end
          sct_pkg::ACT_REMOVE: begin
            if (hit_r) begin
              if (CW'(slot_r) == cnt_last) begin
                cnt_nxt = cnt_last;
              end else begin
                iss_nxt    = CW'(slot_r) + CW'(1);
                state_nxt  = S_SWEEP;
                strobe_nxt = 1'b0;
              end
            end
          end
          default: begin
            ohit_nxt = 1'b0;
          end
        endcase
      end
      S_SWEEP: begin
        if (pend_v_r) begin
          wr_en = 1'b1;
          if (act_r == sct_pkg::ACT_REMOVE) begin
            wr_addr = pend_idx_r - AW'(1);
            wr_data = rd_q;
          end else begin
            wr_addr = pend_idx_r;
            wr_data = {rd_row, rd_col, product};
          end
          if (last) begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            ohit_nxt   = hit_r;
            if (act_r == sct_pkg::ACT_REMOVE) begin
              cnt_nxt = cnt_last;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
    end
    act_r      <= act_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    op_r       <= op_nxt;
    iss_r      <= iss_nxt;
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    old_r      <= old_nxt;
    hit_r      <= hit_nxt;
    rval_r     <= rval_nxt;
    ohit_r     <= ohit_nxt;
    stat_r     <= stat_nxt;
    ocnt_r     <= cnt_wide[OW-1:0];
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_read_value  = rval_r;
  assign out_hit         = ohit_r;
  assign out_status      = stat_r;
  assign out_entry_count = ocnt_r;

`ifndef ASSERT_OFF
  a_strobe_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start)))
    else $error("result beat without a request in progress");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (!out_hit && cnt_r == CW'(CAPACITY)))
    else $error("dropped insert while the store was not full");

  a_idle_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while still busy");
`endif

endmodule

`default_nettype wire
